@@ hdl/bmbr_pkg.sv @@
// ---------------------------------------------------------------------------
// bmbr_pkg
// Types and codes shared by the bicolor matrix block rotator.
// ---------------------------------------------------------------------------
package bmbr_pkg;

    // orientation codes
    localparam logic [1:0] ORIENT_TRANSPOSE = 2'd0;
    localparam logic [1:0] ORIENT_DIRECT    = 2'd1;
    localparam logic [1:0] ORIENT_MIRRORED  = 2'd2;
    localparam logic [1:0] ORIENT_BYTE_REV  = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ORIENTATION = 2'd0;
    localparam logic [1:0] REG_MIRROR_X    = 2'd1;
    localparam logic [1:0] REG_BASE_ADDR   = 2'd2;

    localparam logic [6:0] BASE_ADDR_RESET = 7'd112;
    localparam logic [2:0] LAST_COL        = 3'd7;

    typedef logic [7:0][15:0] rows_t;

    typedef struct packed {
        logic [2:0]  chip_index;
        logic        rotate_half_turn;
        logic [15:0] row0;
        logic [15:0] row1;
        logic [15:0] row2;
        logic [15:0] row3;
        logic [15:0] row4;
        logic [15:0] row5;
        logic [15:0] row6;
        logic [15:0] row7;
    } blk_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [3:0]  ram_address;
        logic [15:0] column_word;
        logic        last;
    } col_t;

    typedef struct packed {
        logic [1:0] orientation;
        logic       mirror_x;
        logic [6:0] base_device_address;
    } cfg_t;

endpackage

@@ hdl/bicolor_matrix_block_rotator_unit.sv @@
// ---------------------------------------------------------------------------
// bicolor_matrix_block_rotator_unit
// Turns an 8-row two-color block into eight column words for a driver RAM.
// ---------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------
//  blk     | blk_valid / blk_stall (out)    | blk_t: chip, half turn, rows
//  col     | col_valid / col_stall (in)     | col_t: addresses, word, last
//  config  | psel penable pwrite paddr ...  | 3 registers at 0x0, 0x4, 0x8
//
//  Each request yields eight column words, one per cycle through the column
//  counter unless col_stall holds it; the next request is taken in the cycle
//  its last column issues. Output register decouples the sides. Reset clears
//  valid flags and the registers to their defaults.
//  col_stall holds the output register and the column counter.
// ---------------------------------------------------------------------------
module bicolor_matrix_block_rotator_unit
    import bmbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        blk_valid,
    output logic        blk_stall,
    input  blk_t        blk,
    output logic        col_valid,
    input  logic        col_stall,
    output col_t        col
);

    cfg_t        cfg;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic [2:0]  col_cnt_reg;
    logic [2:0]  col_cnt_next;
    rows_t       rows_reg;
    logic [1:0]  orient_reg;
    logic [6:0]  dev_reg;
    logic        col_valid_reg;
    logic        col_valid_next;
    col_t        col_reg;
    logic        advance;
    logic        accept;
    logic [15:0] word;

    bmbr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmbr_column u_column (
        .rows   (rows_reg),
        .orient (orient_reg),
        .flip   (cfg.mirror_x),
        .col    (col_cnt_reg),
        .word   (word)
    );

    assign advance   = hold_valid_reg && (!col_valid_reg || !col_stall);
    assign blk_stall = hold_valid_reg && !(advance && (col_cnt_reg == LAST_COL));
    assign accept    = blk_valid && !blk_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        col_cnt_next    = col_cnt_reg;
        if (advance)
        begin
            col_cnt_next = col_cnt_reg + 3'd1;
            if (col_cnt_reg == LAST_COL)
                hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next = 1'b1;
            col_cnt_next    = 3'd0;
        end

        if (advance)
            col_valid_next = 1'b1;
        else if (!col_stall)
            col_valid_next = 1'b0;
        else
            col_valid_next = col_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            col_cnt_reg    <= 3'd0;
            col_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            col_cnt_reg    <= col_cnt_next;
            col_valid_reg  <= col_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rows_reg   <= {blk.row7, blk.row6, blk.row5, blk.row4,
                           blk.row3, blk.row2, blk.row1, blk.row0};
            orient_reg <= cfg.orientation ^ {blk.rotate_half_turn, 1'b0};
            dev_reg    <= cfg.base_device_address | {3'd0, blk.chip_index, 1'b0};
        end
        if (advance)
        begin
            col_reg.device_address <= dev_reg;
            col_reg.ram_address    <= {col_cnt_reg, 1'b0};
            col_reg.column_word    <= word;
            col_reg.last           <= (col_cnt_reg == LAST_COL);
        end
    end

    assign col_valid = col_valid_reg;
    assign col       = col_reg;

endmodule

@@ hdl/bmbr_cfg.sv @@
// ---------------------------------------------------------------------------
// bmbr_cfg
// APB register file: orientation, mirror_x, base_device_address.
// ---------------------------------------------------------------------------
module bmbr_cfg
    import bmbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [1:0] orientation_reg;
    logic       mirror_x_reg;
    logic [6:0] base_addr_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg <= ORIENT_TRANSPOSE;
            mirror_x_reg    <= 1'b0;
            base_addr_reg   <= BASE_ADDR_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_ORIENTATION: orientation_reg <= pwdata[1:0];
                REG_MIRROR_X:    mirror_x_reg    <= pwdata[0];
                REG_BASE_ADDR:   base_addr_reg   <= pwdata[6:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ORIENTATION: prdata = {30'd0, orientation_reg};
            REG_MIRROR_X:    prdata = {31'd0, mirror_x_reg};
            REG_BASE_ADDR:   prdata = {25'd0, base_addr_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.orientation         = orientation_reg;
    assign cfg.mirror_x            = mirror_x_reg;
    assign cfg.base_device_address = base_addr_reg;

endmodule

@@ hdl/bmbr_column.sv @@
// ---------------------------------------------------------------------------
// bmbr_column
// Forms one oriented, bit-reversed 16-bit column word from an 8-row block.
// ---------------------------------------------------------------------------
module bmbr_column
    import bmbr_pkg::*;
(
    input  rows_t       rows,
    input  logic [1:0]  orient,
    input  logic        flip,
    input  logic [2:0]  col,
    output logic [15:0] word
);

    logic [2:0]  src_col;
    logic        flip_eff;
    logic [15:0] b;
    logic [15:0] r;

    // mirrored transpose = transpose of column 7-col with the flip inverted
    assign src_col  = (orient == ORIENT_MIRRORED) ? ~col : col;
    assign flip_eff = flip ^ (orient == ORIENT_MIRRORED);
    assign r        = rows[~col];

    always_comb
    begin
        b = 16'd0;
        case (orient)
            ORIENT_TRANSPOSE, ORIENT_MIRRORED:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    if (flip_eff)
                    begin
                        b[i]     = rows[i][{1'b0, src_col}];
                        b[i + 8] = rows[i][{1'b1, src_col}];
                    end
                    else
                    begin
                        b[7 - i]  = rows[i][{1'b0, src_col}];
                        b[15 - i] = rows[i][{1'b1, src_col}];
                    end
                end
            end
            ORIENT_DIRECT:
                b = rows[col];
            ORIENT_BYTE_REV:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    b[7 - i]  = r[i];
                    b[15 - i] = r[i + 8];
                end
            end
            default:
                b = 16'd0;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
            word[15 - k] = b[k];
    end

endmodule

@@ tb/bicolor_matrix_block_rotator_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bicolor_matrix_block_rotator_unit_tb
// Self-checking bench for the two-color matrix block rotator. A directed
// table covers every orientation, the half-turn flag, mirror on and off,
// and address overlap. Random blocks follow under several register settings
// and idle/stall mixes. Every column word is checked against a local model or a fixed expected value.
// ---------------------------------------------------------------------------
module bicolor_matrix_block_rotator_unit_tb;
    import bmbr_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          RAND_PHASES  = 4;
    localparam int          RAND_PER_PH  = 25;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;   // decodes to no register
    localparam logic [127:0] PAT_A = 128'h0301_0F07_3F1F_FF7F_01FE_0CF0_35C3_A55A;
    localparam logic [127:0] PAT_B = 128'hF00F_1E3C_7788_0001_8000_C3A5_5A96_6C36;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        blk_valid = 1'b0;
    logic        blk_stall;
    blk_t        blk = '0;
    logic        col_valid;
    logic        col_stall = 1'b0;
    col_t        col;

    typedef struct {
        cfg_t        cfg;
        blk_t        item;
        bit          known;
        logic [15:0] word;
        logic [6:0]  dev;
    } dir_row_t;

    dir_row_t dir_rows[$];
    col_t     pending_cols[$];
    cfg_t     cur_cfg;
    int       mismatches = 0;
    int       cycles = 0;
    int       snd_idle_pct = 0;
    int       rcv_stall_pct = 0;

    bicolor_matrix_block_rotator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk       (blk),
        .col_valid (col_valid),
        .col_stall (col_stall),
        .col       (col)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("** bicolor_matrix_block_rotator_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        col_stall <= ($urandom_range(0, 99) < rcv_stall_pct);

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", what, want, got);
        end
    endtask

    // expected word for one column of a block under the given registers
    function automatic col_t rotate_column(input blk_t b, input cfg_t c, input int k);
        rows_t       r;
        logic [1:0]  orient;
        logic [15:0] w;
        logic [15:0] rr;
        col_t        res;
        r = {b.row7, b.row6, b.row5, b.row4, b.row3, b.row2, b.row1, b.row0};
        orient = c.orientation ^ {b.rotate_half_turn, 1'b0};
        w = '0;
        case (orient)
            ORIENT_TRANSPOSE:
                for (int i = 0; i < 8; i++)
                begin
                    if (c.mirror_x)
                    begin
                        w[i]     = r[i][k];
                        w[i + 8] = r[i][k + 8];
                    end
                    else
                    begin
                        w[7 - i]  = r[i][k];
                        w[15 - i] = r[i][k + 8];
                    end
                end
            ORIENT_DIRECT:
                w = r[k];
            ORIENT_MIRRORED:
                for (int i = 0; i < 8; i++)
                begin
                    if (c.mirror_x)
                    begin
                        w[7 - i]  = r[i][7 - k];
                        w[15 - i] = r[i][15 - k];
                    end
                    else
                    begin
                        w[i]     = r[i][7 - k];
                        w[i + 8] = r[i][15 - k];
                    end
                end
            default:
            begin
                rr = r[7 - k];
                for (int i = 0; i < 8; i++)
                begin
                    w[7 - i]  = rr[i];
                    w[15 - i] = rr[i + 8];
                end
            end
        endcase
        for (int i = 0; i < 16; i++)
            res.column_word[15 - i] = w[i];
        // OR, not add: overlapping bits of base and chip merge
        res.device_address = c.base_device_address | {3'b000, b.chip_index, 1'b0};
        res.ram_address    = {k[2:0], 1'b0};
        res.last           = (k[2:0] == LAST_COL);
        return res;
    endfunction

    always @(posedge clk)
    begin : col_check
        col_t want;
        if (rst_n && col_valid && !col_stall)
        begin
            if (pending_cols.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected column word %h", col);
            end
            else
            begin
                want = pending_cols.pop_front();
                check_field("device_address", 32'(want.device_address),
                            32'(col.device_address));
                check_field("ram_address", 32'(want.ram_address), 32'(col.ram_address));
                check_field("column_word", 32'(want.column_word), 32'(col.column_word));
                check_field("last", 32'(want.last), 32'(col.last));
            end
        end
    end

    task automatic apb_access(input logic [1:0] idx, input bit wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits of each write carry junk; only the register bits count
    task automatic program_regs(input cfg_t c);
        logic [31:0] junk;
        logic [31:0] rd;
        junk = $urandom;
        apb_access(REG_ORIENTATION, 1'b1, {junk[31:2], c.orientation}, rd);
        junk = $urandom;
        apb_access(REG_MIRROR_X, 1'b1, {junk[31:1], c.mirror_x}, rd);
        junk = $urandom;
        apb_access(REG_BASE_ADDR, 1'b1, {junk[31:7], c.base_device_address}, rd);
        // write to an unmapped index must leave everything alone
        apb_access(REG_UNUSED, 1'b1, $urandom, rd);
        apb_access(REG_ORIENTATION, 1'b0, '0, rd);
        check_field("orientation readback", 32'(c.orientation), 32'(rd[1:0]));
        apb_access(REG_MIRROR_X, 1'b0, '0, rd);
        check_field("mirror_x readback", 32'(c.mirror_x), 32'(rd[0]));
        apb_access(REG_BASE_ADDR, 1'b0, '0, rd);
        check_field("base_device_address readback", 32'(c.base_device_address),
                    32'(rd[6:0]));
        cur_cfg = c;
    endtask

    task automatic wait_drained(input int tail);
        while (pending_cols.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic send_block(input blk_t b, input bit known,
                              input logic [15:0] word, input logic [6:0] dev);
        col_t c;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            blk_valid <= 1'b0;
            @(posedge clk);
        end
        blk_valid <= 1'b1;
        blk       <= b;
        do
            @(posedge clk);
        while (blk_stall);
        for (int k = 0; k < 8; k++)
        begin
            if (known)
            begin
                c.device_address = dev;
                c.ram_address    = {k[2:0], 1'b0};
                c.column_word    = word;
                c.last           = (k[2:0] == LAST_COL);
            end
            else
                c = rotate_column(b, cur_cfg, k);
            pending_cols = {pending_cols, c};
        end
    endtask

    task automatic add_dir(input cfg_t c, input logic [2:0] chip, input bit half,
                           input logic [127:0] rows, input bit known,
                           input logic [15:0] word, input logic [6:0] dev);
        dir_row_t d;
        d.cfg   = c;
        d.item  = {chip, half, rows};
        d.known = known;
        d.word  = word;
        d.dev   = dev;
        dir_rows = {dir_rows, d};
    endtask

    initial
    begin : stimulus
        cfg_t        c;
        blk_t        b;
        logic [15:0] rw;
        cur_cfg = {ORIENT_TRANSPOSE, 1'b0, BASE_ADDR_RESET};

        // values after reset, then each orientation with and without flip
        add_dir({ORIENT_TRANSPOSE, 1'b0, BASE_ADDR_RESET}, 3'd0, 1'b0, '0, 1'b1, 16'h0000, 7'd112);
        add_dir({ORIENT_TRANSPOSE, 1'b0, BASE_ADDR_RESET}, 3'd7, 1'b1, '1, 1'b1, 16'hFFFF, 7'd126);
        add_dir({ORIENT_TRANSPOSE, 1'b0, BASE_ADDR_RESET}, 3'd3, 1'b0, PAT_A, 1'b0, '0, '0);
        add_dir({ORIENT_TRANSPOSE, 1'b0, BASE_ADDR_RESET}, 3'd3, 1'b1, PAT_A, 1'b0, '0, '0);
        add_dir({ORIENT_TRANSPOSE, 1'b1, BASE_ADDR_RESET}, 3'd1, 1'b0, PAT_A, 1'b0, '0, '0);
        add_dir({ORIENT_TRANSPOSE, 1'b1, BASE_ADDR_RESET}, 3'd6, 1'b1, PAT_B, 1'b0, '0, '0);
        // flip has no effect on direct and byte-reversed
        add_dir({ORIENT_DIRECT, 1'b1, 7'd0}, 3'd2, 1'b0, PAT_A, 1'b0, '0, '0);
        add_dir({ORIENT_DIRECT, 1'b1, 7'd0}, 3'd0, 1'b0, '0,    1'b1, 16'h0000, 7'd0);
        add_dir({ORIENT_DIRECT, 1'b1, 7'd0}, 3'd4, 1'b1, PAT_B, 1'b0, '0, '0);
        add_dir({ORIENT_MIRRORED, 1'b0, 7'd127}, 3'd1, 1'b0, PAT_A, 1'b0, '0, '0);
        add_dir({ORIENT_MIRRORED, 1'b0, 7'd127}, 3'd7, 1'b0, '1,    1'b1, 16'hFFFF, 7'd127);
        add_dir({ORIENT_MIRRORED, 1'b0, 7'd127}, 3'd5, 1'b1, PAT_B, 1'b0, '0, '0);
        add_dir({ORIENT_MIRRORED, 1'b1, 7'd127}, 3'd3, 1'b0, PAT_B, 1'b0, '0, '0);
        // base and chip bits overlap
        add_dir({ORIENT_BYTE_REV, 1'b0, 7'h55}, 3'd5, 1'b0, PAT_A, 1'b0, '0, '0);
        add_dir({ORIENT_BYTE_REV, 1'b0, 7'h55}, 3'd2, 1'b1, PAT_B, 1'b0, '0, '0);
        add_dir({ORIENT_BYTE_REV, 1'b1, 7'd0}, 3'd6, 1'b0, PAT_A, 1'b0, '0, '0);
        add_dir({ORIENT_BYTE_REV, 1'b1, 7'd0}, 3'd0, 1'b1, '1,    1'b1, 16'hFFFF, 7'd0);
        add_dir({ORIENT_DIRECT, 1'b0, 7'h2A}, 3'd5, 1'b0, PAT_B, 1'b0, '0, '0);
        add_dir({ORIENT_DIRECT, 1'b0, 7'h2A}, 3'd7, 1'b1, PAT_A, 1'b0, '0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg != cur_cfg)
            begin
                blk_valid <= 1'b0;
                wait_drained(4);
                program_regs(dir_rows[i].cfg);
            end
            send_block(dir_rows[i].item, dir_rows[i].known, dir_rows[i].word,
                       dir_rows[i].dev);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            blk_valid <= 1'b0;
            wait_drained(4);
            c.orientation = ph[1:0];
            c.mirror_x    = 1'($urandom_range(0, 1));
            c.base_device_address = (ph == 0) ? 7'd127 :
                                    (ph == 1) ? 7'd0 : 7'($urandom_range(0, 127));
            program_regs(c);
            case (ph)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 59; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 59; end
                default: begin snd_idle_pct = 22; rcv_stall_pct = 22; end
            endcase
            for (int n = 0; n < RAND_PER_PH; n++)
            begin
                if (n == RAND_PER_PH / 2)
                begin
                    // hold off until the unit has emptied
                    blk_valid <= 1'b0;
                    wait_drained(0);
                end
                b.chip_index       = 3'($urandom_range(0, 7));
                b.rotate_half_turn = 1'($urandom_range(0, 1));
                for (int k = 0; k < 8; k++)
                begin
                    case ($urandom_range(0, 5))
                        0: rw = 16'h0000;
                        1: rw = 16'hFFFF;
                        default: rw = 16'($urandom);
                    endcase
                    case (k)
                        0: b.row0 = rw;
                        1: b.row1 = rw;
                        2: b.row2 = rw;
                        3: b.row3 = rw;
                        4: b.row4 = rw;
                        5: b.row5 = rw;
                        6: b.row6 = rw;
                        default: b.row7 = rw;
                    endcase
                end
                send_block(b, 1'b0, '0, '0);
            end
        end

        blk_valid <= 1'b0;
        wait_drained(16);
        if (mismatches == 0 && pending_cols.size() == 0)
            $display("** bicolor_matrix_block_rotator_unit: PASSED **");
        else
            $display("** bicolor_matrix_block_rotator_unit: FAILED **");
        $finish;
    end

endmodule
